// ----- hdl/rlsc_pkg.sv -----
// Package for the ring line sensor classifier.
// Holds the shared widths, mode and class codes, table port structs and the
// divide-by-ten helper. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rlsc_pkg;

    localparam int SENSORS_DEF  = 24;
    localparam int RD_W         = 10;
    localparam int IDX_PORT_W   = 5;
    localparam int CNT_W        = 5;
    localparam int SEG_W        = 4;
    localparam int SUM_W        = RD_W + 4;
    localparam int RECIP_W      = 13;
    localparam int PROD_W       = SUM_W + RECIP_W;

    localparam logic [CNT_W-1:0]   LIMIT_RESET = 5'd12;
    localparam logic [CNT_W-1:0]   CNT_MAX     = '1;
    localparam logic [SEG_W-1:0]   SEG_MAX     = '1;
    // Scaled reciprocal of ten: 6554 / 2^16.
    localparam logic [RECIP_W-1:0] RECIP_TEN   = 13'd6554;
    localparam int                 RECIP_SHIFT = 16;

    typedef enum logic [1:0] {
        MODE_SAMPLE   = 2'd0,
        MODE_LOAD_LINE = 2'd1,
        MODE_LOAD_LIFT = 2'd2,
        MODE_UNUSED   = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        CLASS_FIELD  = 2'd0,
        CLASS_LINE   = 2'd1,
        CLASS_LIFTED = 2'd2
    } class_t;

    // Per-sensor values read for the item at hand.
    typedef struct packed {
        logic            seen;
        logic [RD_W-1:0] prev;
        logic [RD_W-1:0] line_thr;
        logic [RD_W-1:0] lift_thr;
    } tbl_rd_t;

    // Write requests into the per-sensor tables.
    typedef struct packed {
        logic            sample_we;
        logic            line_we;
        logic            lift_we;
        logic [RD_W-1:0] data;
    } tbl_wr_t;

    // floor(x / 10) by reciprocal multiply; exact for every x below 2^SUM_W
    // that the smoothing sum can reach (at most 10 * (2^RD_W - 1)).
    function automatic logic [RD_W-1:0] div_ten(input logic [SUM_W-1:0] x);
        logic [PROD_W-1:0] prod;
        prod = PROD_W'(x) * PROD_W'(RECIP_TEN);
        return prod[RECIP_SHIFT +: RD_W];
    endfunction

endpackage

`default_nettype wire

// ----- hdl/ring_line_sensor_classifier_top.sv -----
// Top level of the ring line sensor classifier: input register, smoothing,
// classification, frame totals and result register.
// Depends on rlsc_pkg and rlsc_tables.
//
// Usage:
// Items enter on in_valid / in_stall with mode, sensor_index and value; a
// transaction completes on a clock edge with in_valid high and in_stall low.
// Samples (mode 0) must arrive in order 0 .. SENSORS-1; each produces one
// result on out_valid / out_stall. Threshold loads (modes 1 and 2), mode 3 and
// indexes at or above SENSORS produce no result. The result of the last sensor
// carries frame_done and the frame totals; other results show zero totals.
// Each result passes through the input register and then the result register
// before it shows on out_valid. Throughput is one item per cycle while no
// sample waits behind a stalled result: the input register feeds the result
// register through one pass of smoothing (one multiply by the reciprocal of
// ten) and compares. When the receiver stalls, the result register holds,
// the input register keeps one item, and in_stall rises only when that item
// is a sample that cannot move on. Loads pass even while a result waits.
// The lift count limit is written on cfg_valid / cfg_ready (always ready) and
// resets to 12. Reset clears the thresholds, first-sample flags and the frame
// totals; no item is lost or repeated across stalls. SENSORS may range 3..32.
`timescale 1ns / 1ps
`default_nettype none

module ring_line_sensor_classifier_top
    import rlsc_pkg::*;
#(
    parameter int SENSORS = SENSORS_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic [1:0]            mode,
    input  wire logic [IDX_PORT_W-1:0] sensor_index,
    input  wire logic [RD_W-1:0]       value,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic [IDX_PORT_W-1:0]      out_index,
    output logic [RD_W-1:0]            filtered_reading,
    output logic [1:0]                 sensor_class,
    output logic                       frame_done,
    output logic [CNT_W-1:0]           line_count,
    output logic [SEG_W-1:0]           segment_count,
    output logic [CNT_W-1:0]           lift_count,
    output logic                       lifted,
    output logic [SENSORS-1:0]         lit_mask,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CNT_W-1:0]      cfg_data
);

    localparam int IDX_W = $clog2(SENSORS);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SENSORS - 1);
    localparam logic [IDX_W-1:0] NEXT_LAST_IDX = IDX_W'(SENSORS - 2);

    // Input register.
    logic                  s1_valid_reg, s1_valid_next;
    mode_t                 s1_mode_reg;
    logic [IDX_PORT_W-1:0] s1_idx_reg;
    logic [RD_W-1:0]       s1_value_reg;

    // Frame state.
    logic [SENSORS-1:0] lit_bits_reg, lit_bits_next;
    logic [CNT_W-1:0]   hit_reg, hit_next;
    logic [SEG_W-1:0]   group_reg, group_next;
    logic [CNT_W-1:0]   lift_reg, lift_next;
    logic [CNT_W-1:0]   limit_reg;

    // Result register.
    logic                  out_valid_reg, out_valid_next;
    logic [IDX_PORT_W-1:0] out_index_reg;
    logic [RD_W-1:0]       filt_reg;
    class_t                class_reg;
    logic                  done_reg;
    logic [CNT_W-1:0]      line_count_reg;
    logic [SEG_W-1:0]      seg_count_reg;
    logic [CNT_W-1:0]      lift_count_reg;
    logic                  lifted_reg;
    logic [SENSORS-1:0]    lit_mask_reg;

    logic               in_accept;
    logic               s1_go;
    logic               s1_fire;
    logic               in_range;
    logic               is_sample;
    logic [IDX_W-1:0]   idx;
    logic               frame_start;
    logic               frame_end;
    tbl_rd_t            rd;
    tbl_wr_t            wr;
    logic [RD_W-1:0]    prev_used;
    logic [SUM_W-1:0]   sum;
    logic [RD_W-1:0]    filt;
    logic               lit;
    logic               low;
    class_t             cls;
    logic [SENSORS-1:0] base_lit;
    logic [CNT_W-1:0]   base_hit;
    logic [SEG_W-1:0]   base_group;
    logic [CNT_W-1:0]   base_lift;
    logic [SENSORS-1:0] sel_bit;
    logic [SENSORS-1:0] lit_upd;
    logic [CNT_W-1:0]   hit_upd;
    logic [SEG_W-1:0]   group_upd;
    logic [CNT_W-1:0]   lift_upd;
    logic               left_lit;
    logic               first_lit;
    logic               prior_lit;
    logic               res_lifted;

    assign cfg_ready = 1'b1;

    // A waiting result blocks only samples; loads make no result.
    assign s1_go     = !(is_sample && out_valid_reg && out_stall);
    assign s1_fire   = s1_valid_reg && s1_go;
    assign in_stall  = s1_valid_reg && !s1_go;
    assign in_accept = in_valid && !in_stall;
    assign s1_valid_next = in_accept || (s1_valid_reg && !s1_go);

    assign in_range  = {1'b0, s1_idx_reg} < (IDX_PORT_W + 1)'(SENSORS);
    assign idx       = s1_idx_reg[IDX_W-1:0];
    assign is_sample = in_range && (s1_mode_reg == MODE_SAMPLE);

    assign frame_start = (idx == '0);
    assign frame_end   = (idx == LAST_IDX);

    rlsc_tables #(
        .SENSORS (SENSORS),
        .IDX_W   (IDX_W)
    ) u_tables (
        .clk   (clk),
        .rst_n (rst_n),
        .idx   (idx),
        .wr    (wr),
        .rd    (rd)
    );

    always_comb
    begin
        wr.sample_we = s1_fire && is_sample;
        wr.line_we   = s1_fire && in_range && (s1_mode_reg == MODE_LOAD_LINE);
        wr.lift_we   = s1_fire && in_range && (s1_mode_reg == MODE_LOAD_LIFT);
        wr.data      = is_sample ? filt : s1_value_reg;
    end

    // A sensor's first sample passes unchanged: (v + 9v) / 10 = v.
    always_comb
    begin
        prev_used = rd.seen ? rd.prev : s1_value_reg;
        sum       = SUM_W'(prev_used) + SUM_W'({s1_value_reg, 3'b000})
                    + SUM_W'(s1_value_reg);
        filt      = div_ten(sum);
        lit       = filt > rd.line_thr;
        low       = !lit && (filt < rd.lift_thr);
        case ({lit, low})
            2'b10:   cls = CLASS_LINE;
            2'b01:   cls = CLASS_LIFTED;
            default: cls = CLASS_FIELD;
        endcase
    end

    always_comb
    begin
        base_lit   = frame_start ? '0 : lit_bits_reg;
        base_hit   = frame_start ? '0 : hit_reg;
        base_group = frame_start ? '0 : group_reg;
        base_lift  = frame_start ? '0 : lift_reg;

        sel_bit   = SENSORS'(1) << idx;
        left_lit  = base_lit[idx - IDX_W'(1)];
        first_lit = base_lit[0];
        prior_lit = base_lit[NEXT_LAST_IDX];

        lit_upd   = (base_lit & ~sel_bit) | (lit ? sel_bit : '0);
        hit_upd   = base_hit;
        group_upd = base_group;
        lift_upd  = base_lift;

        if (lit)
        begin
            if (hit_upd != CNT_MAX)
            begin
                hit_upd = hit_upd + CNT_W'(1);
            end
            // The last sensor closes the ring: it may open a segment or join
            // the segment at sensor zero to the one ending at its left.
            if (frame_end)
            begin
                if (!first_lit && !prior_lit && (base_group != SEG_MAX))
                begin
                    group_upd = base_group + SEG_W'(1);
                end
                else if (first_lit && prior_lit && (base_group != '0))
                begin
                    group_upd = base_group - SEG_W'(1);
                end
            end
            else if ((frame_start || !left_lit) && (base_group != SEG_MAX))
            begin
                group_upd = base_group + SEG_W'(1);
            end
        end
        else if (low && (lift_upd != CNT_MAX))
        begin
            lift_upd = lift_upd + CNT_W'(1);
        end

        res_lifted = lift_upd > limit_reg;

        lit_bits_next = lit_bits_reg;
        hit_next      = hit_reg;
        group_next    = group_reg;
        lift_next     = lift_reg;
        if (s1_fire && is_sample)
        begin
            if (frame_end)
            begin
                lit_bits_next = '0;
                hit_next      = '0;
                group_next    = '0;
                lift_next     = '0;
            end
            else
            begin
                lit_bits_next = lit_upd;
                hit_next      = hit_upd;
                group_next    = group_upd;
                lift_next     = lift_upd;
            end
        end

        out_valid_next = (s1_fire && is_sample) || (out_valid_reg && out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            lit_bits_reg  <= '0;
            hit_reg       <= '0;
            group_reg     <= '0;
            lift_reg      <= '0;
            limit_reg     <= LIMIT_RESET;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            lit_bits_reg  <= lit_bits_next;
            hit_reg       <= hit_next;
            group_reg     <= group_next;
            lift_reg      <= lift_next;
            if (cfg_valid && cfg_ready)
            begin
                limit_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_mode_reg  <= mode_t'(mode);
            s1_idx_reg   <= sensor_index;
            s1_value_reg <= value;
        end
        if (s1_fire && is_sample)
        begin
            out_index_reg  <= s1_idx_reg;
            filt_reg       <= filt;
            class_reg      <= cls;
            done_reg       <= frame_end;
            line_count_reg <= frame_end ? hit_upd : '0;
            seg_count_reg  <= frame_end ? group_upd : '0;
            lift_count_reg <= frame_end ? lift_upd : '0;
            lifted_reg     <= frame_end && res_lifted;
            lit_mask_reg   <= frame_end ? lit_upd : '0;
        end
    end

    assign out_valid        = out_valid_reg;
    assign out_index        = out_index_reg;
    assign filtered_reading = filt_reg;
    assign sensor_class     = class_reg;
    assign frame_done       = done_reg;
    assign line_count       = line_count_reg;
    assign segment_count    = seg_count_reg;
    assign lift_count       = lift_count_reg;
    assign lifted           = lifted_reg;
    assign lit_mask         = lit_mask_reg;

    // The frame-end result always belongs to the last sensor.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && done_reg |-> out_index_reg == IDX_PORT_W'(SENSORS - 1))
        else $error("frame end reported on a sensor other than the last");

    // Totals are shown only on the frame-end result.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !done_reg |->
            line_count_reg == '0 && seg_count_reg == '0 && lift_count_reg == '0
            && !lifted_reg && lit_mask_reg == '0)
        else $error("frame totals shown before the end of the frame");

    // Every segment is opened by a counted line hit.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && done_reg |-> CNT_W'(seg_count_reg) <= line_count_reg)
        else $error("more segments than lit sensors");

    // A processed sample always lands in the result register.
    assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire && is_sample |=> out_valid_reg)
        else $error("sample processed without a result");

endmodule

`default_nettype wire

// ----- hdl/rlsc_tables.sv -----
// Per-sensor storage: smoothed history, first-sample flags and the two
// threshold tables. Depends on rlsc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rlsc_tables
    import rlsc_pkg::*;
#(
    parameter int SENSORS = SENSORS_DEF,
    parameter int IDX_W   = $clog2(SENSORS)
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic [IDX_W-1:0] idx,
    input  wire tbl_wr_t          wr,
    output tbl_rd_t               rd
);

    logic [RD_W-1:0] prev_filtered_reg [SENSORS];
    logic [SENSORS-1:0] prev_seen_reg;
    logic [RD_W-1:0] line_thr_reg [SENSORS];
    logic [RD_W-1:0] lift_thr_reg [SENSORS];

    // The history has no reset; the seen flag decides whether it is used.
    always_ff @(posedge clk)
    begin
        if (wr.sample_we)
        begin
            prev_filtered_reg[idx] <= wr.data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_seen_reg <= '0;
            for (int i = 0; i < SENSORS; i++)
            begin
                line_thr_reg[i] <= '0;
                lift_thr_reg[i] <= '0;
            end
        end
        else
        begin
            if (wr.sample_we)
            begin
                prev_seen_reg[idx] <= 1'b1;
            end
            if (wr.line_we)
            begin
                line_thr_reg[idx] <= wr.data;
            end
            if (wr.lift_we)
            begin
                lift_thr_reg[idx] <= wr.data;
            end
        end
    end

    always_comb
    begin
        rd.seen     = prev_seen_reg[idx];
        rd.prev     = prev_filtered_reg[idx];
        rd.line_thr = line_thr_reg[idx];
        rd.lift_thr = lift_thr_reg[idx];
    end

endmodule

`default_nettype wire

// ----- tb/sv/ring_line_sensor_classifier_top_tb.sv -----
// Self-checking testbench for ring_line_sensor_classifier_top. It drives sensor samples
// and threshold loads, predicts every result and compares each one as it leaves.
// Depends on rlsc_pkg and the top level of the classifier.
`timescale 1ns / 1ps

module ring_line_sensor_classifier_top_tb;
    import rlsc_pkg::*;

    localparam int NUM_SENSORS  = SENSORS_DEF;
    localparam int LAST_SENSOR  = NUM_SENSORS - 1;
    localparam int GAP_PERCENT  = 19;
    localparam int HOLD_CYCLES  = 60;
    localparam int PHASE_ITEMS  = 300;
    localparam int DRAIN_CYCLES = 4;
    localparam int MAX_REPORTS  = 10;
    localparam logic [RD_W-1:0] RD_TOP = '1;

    typedef enum int {READ_LOW, READ_HIGH, READ_RAIL, READ_ANY} reading_style_t;
    typedef enum int {THR_SPREAD, THR_ALL_LIFT, THR_ALL_LINE, THR_PATTERN} threshold_style_t;

    typedef struct packed {
        logic [IDX_PORT_W-1:0] idx;
        logic [RD_W-1:0]       reading;
        class_t                cls;
        logic                  done;
        logic [CNT_W-1:0]      lines;
        logic [SEG_W-1:0]      segs;
        logic [CNT_W-1:0]      lifts;
        logic                  lift_flag;
        logic [NUM_SENSORS-1:0] mask;
    } sensor_result_t;

    logic                   clk;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_stall;
    logic [1:0]             mode;
    logic [IDX_PORT_W-1:0]  sensor_index;
    logic [RD_W-1:0]        value;
    logic                   out_valid;
    logic                   out_stall;
    logic [IDX_PORT_W-1:0]  out_index;
    logic [RD_W-1:0]        filtered_reading;
    logic [1:0]             sensor_class;
    logic                   frame_done;
    logic [CNT_W-1:0]       line_count;
    logic [SEG_W-1:0]       segment_count;
    logic [CNT_W-1:0]       lift_count;
    logic                   lifted;
    logic [NUM_SENSORS-1:0] lit_mask;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CNT_W-1:0]       cfg_data;

    // Predictor state: smoothing history, thresholds and the running frame totals.
    logic [RD_W-1:0]        smooth_prev [NUM_SENSORS];
    logic [NUM_SENSORS-1:0] smooth_seen;
    logic [RD_W-1:0]        line_thr [NUM_SENSORS];
    logic [RD_W-1:0]        lift_thr [NUM_SENSORS];
    logic [NUM_SENSORS-1:0] frame_lit;
    int                     frame_hits;
    int                     frame_groups;
    int                     frame_lifts;
    logic [CNT_W-1:0]       lift_limit;

    sensor_result_t pending_results [$];
    int             mismatch_count;
    int             counted_items;
    bit             gaps_on;
    bit             stall_on;
    bit             holding;

    ring_line_sensor_classifier_top #(
        .SENSORS(NUM_SENSORS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .mode(mode),
        .sensor_index(sensor_index),
        .value(value),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_index(out_index),
        .filtered_reading(filtered_reading),
        .sensor_class(sensor_class),
        .frame_done(frame_done),
        .line_count(line_count),
        .segment_count(segment_count),
        .lift_count(lift_count),
        .lifted(lifted),
        .lit_mask(lit_mask),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    always @(posedge clk)
    begin
        out_stall <= holding || (stall_on && ($urandom_range(99) < GAP_PERCENT));
    end

    function automatic string describe(input sensor_result_t r);
        return $sformatf({"sensor %0d reading %0d class %0d done %0b lines %0d segs %0d ",
                          "lifts %0d lifted %0b mask %06h"},
                         r.idx, r.reading, r.cls, r.done, r.lines, r.segs,
                         r.lifts, r.lift_flag, r.mask);
    endfunction

    always @(posedge clk)
    begin : result_check
        sensor_result_t got;
        sensor_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            got.idx       = out_index;
            got.reading   = filtered_reading;
            got.cls       = class_t'(sensor_class);
            got.done      = frame_done;
            got.lines     = line_count;
            got.segs      = segment_count;
            got.lifts     = lift_count;
            got.lift_flag = lifted;
            got.mask      = lit_mask;
            if (pending_results.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("%0t: result with none expected: %s", $time, describe(got));
            end
            else
            begin
                want = pending_results.pop_front();
                if (got.idx !== want.idx || got.reading !== want.reading ||
                    got.cls !== want.cls || got.done !== want.done ||
                    got.lines !== want.lines || got.segs !== want.segs ||
                    got.lifts !== want.lifts || got.lift_flag !== want.lift_flag ||
                    got.mask !== want.mask)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                    begin
                        $display("%0t: expected %s", $time, describe(want));
                        $display("%0t: actual   %s", $time, describe(got));
                    end
                end
            end
        end
    end

    task automatic clear_frame_totals();
        frame_lit    = '0;
        frame_hits   = 0;
        frame_groups = 0;
        frame_lifts  = 0;
    endtask

    task automatic smooth_and_classify(input mode_t m, input logic [IDX_PORT_W-1:0] idx,
                                       input logic [RD_W-1:0] v);
        sensor_result_t r;
        int             sum;
        logic [RD_W-1:0] filt;
        class_t         cls;
        bit             opens;
        if (idx >= NUM_SENSORS || m == MODE_UNUSED)
            return;
        if (m == MODE_LOAD_LINE)
        begin
            line_thr[idx] = v;
            return;
        end
        if (m == MODE_LOAD_LIFT)
        begin
            lift_thr[idx] = v;
            return;
        end

        if (idx == 0)
            clear_frame_totals();
        // A sensor's first sample since reset passes through the filter unchanged.
        if (!smooth_seen[idx])
        begin
            smooth_prev[idx] = v;
            smooth_seen[idx] = 1'b1;
        end
        sum  = smooth_prev[idx] + 9 * v;
        filt = RD_W'(sum / 10);
        smooth_prev[idx] = filt;

        cls = CLASS_FIELD;
        if (filt > line_thr[idx])
        begin
            cls = CLASS_LINE;
            frame_lit[idx] = 1'b1;
            if (frame_hits < CNT_MAX)
                frame_hits++;
            // The last sensor closes the ring: it may open a segment or join two.
            if (idx == LAST_SENSOR)
            begin
                opens = !frame_lit[0] && !frame_lit[LAST_SENSOR-1];
                if (frame_lit[0] && frame_lit[LAST_SENSOR-1] && frame_groups > 0)
                    frame_groups--;
            end
            else
                opens = (idx == 0) || !frame_lit[idx-1];
            if (opens && frame_groups < SEG_MAX)
                frame_groups++;
        end
        else
        begin
            frame_lit[idx] = 1'b0;
            if (filt < lift_thr[idx])
            begin
                cls = CLASS_LIFTED;
                if (frame_lifts < CNT_MAX)
                    frame_lifts++;
            end
        end

        r         = '0;
        r.idx     = idx;
        r.reading = filt;
        r.cls     = cls;
        if (idx == LAST_SENSOR)
        begin
            r.done      = 1'b1;
            r.lines     = CNT_W'(frame_hits);
            r.segs      = SEG_W'(frame_groups);
            r.lifts     = CNT_W'(frame_lifts);
            r.lift_flag = frame_lifts > lift_limit;
            r.mask      = frame_lit;
            clear_frame_totals();
        end
        pending_results.push_back(r);
    endtask

    task automatic send_item(input mode_t m, input logic [IDX_PORT_W-1:0] idx,
                             input logic [RD_W-1:0] v);
        while (gaps_on && $urandom_range(99) < GAP_PERCENT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        mode         <= m;
        sensor_index <= idx;
        value        <= v;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (idx < NUM_SENSORS && m != MODE_UNUSED)
            counted_items++;
        smooth_and_classify(m, idx, v);
    endtask

    // Lowers valid and lets the pipeline empty, including loads that make no result.
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
    endtask

    task automatic write_lift_limit(input logic [CNT_W-1:0] limit_val);
        cfg_valid <= 1'b1;
        cfg_data  <= limit_val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid  <= 1'b0;
        lift_limit = limit_val;
    endtask

    function automatic logic [RD_W-1:0] pick_reading(input reading_style_t style);
        case (style)
            READ_LOW:  return RD_W'($urandom_range(63));
            READ_HIGH: return RD_W'($urandom_range(RD_TOP, RD_TOP - 63));
            READ_RAIL: return $urandom_range(1) ? RD_TOP : '0;
            default:   return RD_W'($urandom_range(RD_TOP));
        endcase
    endfunction

    task automatic send_frame(input int first, input int last);
        reading_style_t style;
        style = reading_style_t'($urandom_range(3));
        for (int i = first; i <= last; i++)
        begin
            if ($urandom_range(99) < 5)
                send_item($urandom_range(1) ? MODE_LOAD_LINE : MODE_LOAD_LIFT,
                          IDX_PORT_W'($urandom_range(LAST_SENSOR)),
                          RD_W'($urandom_range(RD_TOP)));
            send_item(MODE_SAMPLE, IDX_PORT_W'(i), pick_reading(style));
        end
    endtask

    task automatic retarget_thresholds();
        threshold_style_t style;
        logic [RD_W-1:0]  line_v;
        logic [RD_W-1:0]  lift_v;
        style = threshold_style_t'($urandom_range(3));
        for (int i = 0; i < NUM_SENSORS; i++)
        begin
            case (style)
                THR_SPREAD:
                begin
                    line_v = RD_W'($urandom_range(RD_TOP));
                    lift_v = RD_W'($urandom_range(RD_TOP));
                end
                THR_ALL_LIFT:
                begin
                    line_v = RD_TOP;
                    lift_v = RD_TOP;
                end
                THR_ALL_LINE:
                begin
                    line_v = '0;
                    lift_v = RD_W'($urandom_range(RD_TOP));
                end
                default:
                begin
                    line_v = $urandom_range(1) ? RD_TOP : '0;
                    lift_v = RD_W'($urandom_range(RD_TOP));
                end
            endcase
            send_item(MODE_LOAD_LINE, IDX_PORT_W'(i), line_v);
            send_item(MODE_LOAD_LIFT, IDX_PORT_W'(i), lift_v);
        end
    endtask

    // Unused mode and indexes past the ring must be dropped without a result.
    task automatic test_ignored_items();
        send_item(MODE_UNUSED, '0, RD_TOP);
        send_item(MODE_SAMPLE, IDX_PORT_W'(NUM_SENSORS), RD_TOP);
        send_item(MODE_SAMPLE, IDX_PORT_W'(31), '0);
        send_item(MODE_LOAD_LINE, IDX_PORT_W'(31), RD_TOP);
        send_item(MODE_LOAD_LIFT, IDX_PORT_W'(NUM_SENSORS), RD_TOP);
        send_item(MODE_UNUSED, IDX_PORT_W'(LAST_SENSOR), '0);
    endtask

    // First samples pass unfiltered; the second pass uses the stored history.
    task automatic test_first_samples();
        send_item(MODE_LOAD_LINE, '0, RD_TOP);
        send_item(MODE_LOAD_LIFT, '0, '0);
        send_item(MODE_LOAD_LINE, IDX_PORT_W'(1), '0);
        send_item(MODE_LOAD_LINE, IDX_PORT_W'(LAST_SENSOR - 1), RD_TOP);
        send_item(MODE_LOAD_LIFT, IDX_PORT_W'(LAST_SENSOR - 1), RD_TOP);
        send_item(MODE_LOAD_LINE, IDX_PORT_W'(LAST_SENSOR), '0);
        send_item(MODE_SAMPLE, '0, '0);
        send_item(MODE_SAMPLE, IDX_PORT_W'(1), RD_TOP);
        send_item(MODE_SAMPLE, IDX_PORT_W'(LAST_SENSOR - 1), 10'd512);
        send_item(MODE_SAMPLE, IDX_PORT_W'(LAST_SENSOR), RD_TOP);
        send_item(MODE_SAMPLE, '0, RD_TOP);
        send_item(MODE_SAMPLE, IDX_PORT_W'(LAST_SENSOR), '0);
    endtask

    task automatic test_lift_flag();
        wait_idle();
        write_lift_limit('0);
        send_item(MODE_SAMPLE, IDX_PORT_W'(LAST_SENSOR - 1), '0);
        send_item(MODE_SAMPLE, IDX_PORT_W'(LAST_SENSOR), RD_TOP);
    endtask

    // The receiver holds off while a full frame keeps coming, so the input backs up.
    task automatic test_backpressure();
        wait_idle();
        gaps_on = 1'b0;
        stall_on <= 1'b0;
        fork
            begin
                holding <= 1'b1;
                repeat (HOLD_CYCLES)
                    @(posedge clk);
                holding <= 1'b0;
            end
            begin
                send_item(MODE_LOAD_LIFT, IDX_PORT_W'(3), 10'd700);
                send_frame(0, LAST_SENSOR);
            end
        join
    endtask

    task automatic test_random_frames(input logic [CNT_W-1:0] limit_val, input bit with_gaps);
        int             start_count;
        int             pick;
        int             sensor;
        int             cut;
        reading_style_t style;
        wait_idle();
        write_lift_limit(limit_val);
        gaps_on = with_gaps;
        stall_on <= with_gaps;
        start_count = counted_items;
        while (counted_items - start_count < PHASE_ITEMS)
        begin
            pick = $urandom_range(99);
            if (pick < 10)
                retarget_thresholds();
            else if (pick < 70)
                send_frame(0, LAST_SENSOR);
            else if (pick < 80)
            begin
                // A frame cut short, or one that starts without sensor 0.
                cut = $urandom_range(LAST_SENSOR);
                if ($urandom_range(1))
                    send_frame(0, cut);
                else
                    send_frame(cut, LAST_SENSOR);
            end
            else if (pick < 90)
            begin
                // One sensor sampled over and over pushes the counters to saturation.
                sensor = $urandom_range(LAST_SENSOR);
                style  = reading_style_t'($urandom_range(3));
                repeat ($urandom_range(1, 40))
                    send_item(MODE_SAMPLE, IDX_PORT_W'(sensor), pick_reading(style));
            end
            else if ($urandom_range(1))
                send_item(MODE_UNUSED, IDX_PORT_W'($urandom_range(31)),
                          RD_W'($urandom_range(RD_TOP)));
            else
                send_item(mode_t'($urandom_range(2)),
                          IDX_PORT_W'($urandom_range(31, NUM_SENSORS)),
                          RD_W'($urandom_range(RD_TOP)));
        end
    endtask

    initial
    begin
        in_valid     <= 1'b0;
        mode         <= MODE_SAMPLE;
        sensor_index <= '0;
        value        <= '0;
        cfg_valid    <= 1'b0;
        cfg_data     <= '0;
        holding      <= 1'b0;
        stall_on     <= 1'b1;
        rst_n        <= 1'b0;
        gaps_on        = 1'b1;
        counted_items  = 0;
        mismatch_count = 0;
        for (int i = 0; i < NUM_SENSORS; i++)
        begin
            smooth_prev[i] = '0;
            line_thr[i]    = '0;
            lift_thr[i]    = '0;
        end
        smooth_seen = '0;
        lift_limit  = LIMIT_RESET;
        clear_frame_totals();

        repeat (2)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_ignored_items();
        test_first_samples();
        test_lift_flag();
        test_backpressure();
        test_random_frames('0, 1'b1);
        test_random_frames(5'd24, 1'b1);
        test_random_frames(5'd31, 1'b0);
        test_random_frames(CNT_W'($urandom_range(1, 23)), 1'b1);
        test_random_frames(LIMIT_RESET, 1'b1);
        wait_idle();

        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        #1_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

// ----- sim.f -----
hdl/rlsc_pkg.sv
hdl/rlsc_tables.sv
hdl/ring_line_sensor_classifier_top.sv
tb/sv/ring_line_sensor_classifier_top_tb.sv
